[hw/rtl/hss_pkg.sv]
// Shared constants, types and helper functions of the half-step stepper sequencer.
package hss_pkg;

    // Number of mechanical positions before the position counter wraps.
    localparam int unsigned POSITIONS = 400;
    localparam int unsigned POS_W     = $clog2(POSITIONS);

    // Field widths of the item and result payloads.
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned OUT_POS_W = 9;
    localparam int unsigned CNT_W     = 16;
    // Remaining-step counter holds a full 32768 for the most negative count.
    localparam int unsigned LEFT_W    = STEP_W + 1;

    // Configuration register widths and indexes.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UNIT = 2'd2;

    // Register reset values.
    localparam logic [6:0]  SPEED_RESET      = 7'd100;
    localparam logic [15:0] PULSE_RESET      = 16'd3000;
    localparam logic [7:0]  DELAY_UNIT_RESET = 8'd10;
    localparam logic [6:0]  SPEED_FULL       = 7'd100;

    // Command codes carried in the input tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Configuration register file as seen by the step engine.
    typedef struct packed {
        logic [6:0]  speed;
        logic [15:0] pulse_ticks;
        logic [7:0]  delay_unit;
    } hss_cfg_t;

    // One result item.
    typedef struct packed {
        logic                 rejected;
        logic                 busy_res;
        logic [OUT_POS_W-1:0] position;
        logic [2:0]           phase;
        logic [3:0]           coils;
    } hss_result_t;

    // Coil pattern of each half-step phase: A, AB, B, BC, C, CD, D, DA.
    function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        unique case (phase)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

    // Next phase in the direction of travel, wrapping over eight phases.
    function automatic logic [2:0] phase_step(input logic [2:0] phase, input logic backwards);
        return backwards ? phase - 3'd1 : phase + 3'd1;
    endfunction

endpackage

[hw/rtl/hss_engine.sv]
// Step engine: sequencer state registers and the per-item next-state and result logic.
module hss_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_en,
    input  logic                       command,
    input  logic [hss_pkg::STEP_W-1:0] step_count,
    input  hss_pkg::hss_cfg_t          cfg,
    output hss_pkg::hss_result_t       result
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ON    = 2'd1,
        ST_OFF   = 2'd2,
        ST_PAUSE = 2'd3
    } stage_t;

    stage_t                      stage_reg, stage_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [hss_pkg::POS_W-1:0]   position_reg, position_next;
    logic [hss_pkg::LEFT_W-1:0]  steps_left_reg, steps_left_next;
    logic                        backwards_reg, backwards_next;
    logic [hss_pkg::CNT_W-1:0]   tick_counter_reg, tick_counter_next;

    logic [hss_pkg::CNT_W:0]     cnt_inc;
    logic [hss_pkg::CNT_W-1:0]   pulse_len;
    logic [6:0]                  deficit;
    logic [14:0]                 pause_len;
    logic [hss_pkg::LEFT_W-1:0]  steps_dec;
    logic [31:0]                 pos_ext;
    logic                        rejected;

    // Stage lengths from the current register values.
    assign pulse_len = (cfg.pulse_ticks == '0) ? hss_pkg::CNT_W'(1) : cfg.pulse_ticks;
    assign deficit   = (cfg.speed >= hss_pkg::SPEED_FULL) ? 7'd0
                                                          : hss_pkg::SPEED_FULL - cfg.speed;
    assign pause_len = 15'(deficit) * 15'(cfg.delay_unit);
    assign cnt_inc   = {1'b0, tick_counter_reg} + 17'd1;
    assign steps_dec = (steps_left_reg != '0) ? steps_left_reg - 1'b1 : steps_left_reg;

    // Next state for one accepted item.
    always_comb begin
        stage_next        = stage_reg;
        phase_next        = phase_reg;
        position_next     = position_reg;
        steps_left_next   = steps_left_reg;
        backwards_next    = backwards_reg;
        tick_counter_next = tick_counter_reg;
        rejected          = 1'b0;
        if (item_en) begin
            if (command == hss_pkg::CMD_MOVE) begin
                if (stage_reg != ST_IDLE) begin
                    rejected = 1'b1;
                end else if (step_count != '0) begin
                    backwards_next    = step_count[hss_pkg::STEP_W-1];
                    steps_left_next   = step_count[hss_pkg::STEP_W-1]
                                      ? (17'h10000 - {1'b0, step_count})
                                      : {1'b0, step_count};
                    phase_next        = hss_pkg::phase_step(phase_reg,
                                                            step_count[hss_pkg::STEP_W-1]);
                    stage_next        = ST_ON;
                    tick_counter_next = '0;
                end
            end else begin
                unique case (stage_reg)
                    ST_ON: begin
                        if (cnt_inc >= {1'b0, pulse_len}) begin
                            stage_next        = ST_OFF;
                            tick_counter_next = '0;
                        end else begin
                            tick_counter_next = cnt_inc[hss_pkg::CNT_W-1:0];
                        end
                    end
                    ST_OFF: begin
                        if (cnt_inc >= {1'b0, pulse_len}) begin
                            // Step is complete: move the position and count the step.
                            if (backwards_reg) begin
                                position_next = (position_reg == '0)
                                    ? hss_pkg::POS_W'(hss_pkg::POSITIONS - 1)
                                    : position_reg - 1'b1;
                            end else begin
                                position_next = (32'(position_reg) + 32'd1 >= hss_pkg::POSITIONS)
                                    ? '0 : position_reg + 1'b1;
                            end
                            steps_left_next   = steps_dec;
                            tick_counter_next = '0;
                            if (pause_len != '0) begin
                                stage_next = ST_PAUSE;
                            end else if (steps_dec != '0) begin
                                // No pause: the next step starts on this same tick.
                                phase_next = hss_pkg::phase_step(phase_reg, backwards_reg);
                                stage_next = ST_ON;
                            end else begin
                                stage_next = ST_IDLE;
                            end
                        end else begin
                            tick_counter_next = cnt_inc[hss_pkg::CNT_W-1:0];
                        end
                    end
                    ST_PAUSE: begin
                        if (cnt_inc >= 17'(pause_len)) begin
                            tick_counter_next = '0;
                            if (steps_left_reg != '0) begin
                                phase_next = hss_pkg::phase_step(phase_reg, backwards_reg);
                                stage_next = ST_ON;
                            end else begin
                                stage_next = ST_IDLE;
                            end
                        end else begin
                            tick_counter_next = cnt_inc[hss_pkg::CNT_W-1:0];
                        end
                    end
                    default: begin
                        // A tick while idle changes nothing.
                    end
                endcase
            end
        end
    end

    // Result reflects the state after the item is applied.
    assign pos_ext = 32'(position_next);
    always_comb begin
        result.coils    = (stage_next == ST_ON) ? hss_pkg::coil_pattern(phase_next) : 4'd0;
        result.phase    = phase_next;
        result.position = pos_ext[hss_pkg::OUT_POS_W-1:0];
        result.busy_res = (stage_next != ST_IDLE);
        result.rejected = rejected;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg        <= ST_IDLE;
            phase_reg        <= '0;
            position_reg     <= '0;
            steps_left_reg   <= '0;
            backwards_reg    <= 1'b0;
            tick_counter_reg <= '0;
        end else begin
            stage_reg        <= stage_next;
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            steps_left_reg   <= steps_left_next;
            backwards_reg    <= backwards_next;
            tick_counter_reg <= tick_counter_next;
        end
    end

endmodule

[hw/rtl/half_step_stepper_sequencer.sv]
// Top level of the half-step stepper sequencer: handshakes, configuration and result register.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser[0] command; tdata[15:0] step_count
//   m_axis    out        tdata coils[3:0] phase[6:4] position[15:7] busy_res[16] rejected[17]
//   cfg       in         cfg_addr selects speed / pulse_ticks / delay_unit, cfg_data
//
// The step engine updates its state and forms the result in the cycle of acceptance,
// and the result register shows it on the next cycle.
// A new item is taken each cycle while the result register is empty or being drained.
// When m_tready is low with a result held, s_tready drops and nothing is lost.
// aresetn is synchronous; it clears engine state and result valid and loads register defaults.
module half_step_stepper_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // step_count[15:0]
    input  logic [0:0]                    s_tuser,   // command[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // coils, phase, position, busy_res, rejected
    input  logic                          cfg_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data
);

    hss_pkg::hss_cfg_t    cfg_reg;
    hss_pkg::hss_result_t result;
    hss_pkg::hss_result_t result_reg;
    logic                 m_tvalid_reg;
    logic                 item_en;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign item_en  = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed       <= hss_pkg::SPEED_RESET;
            cfg_reg.pulse_ticks <= hss_pkg::PULSE_RESET;
            cfg_reg.delay_unit  <= hss_pkg::DELAY_UNIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                hss_pkg::CFG_SPEED:      cfg_reg.speed       <= cfg_data[6:0];
                hss_pkg::CFG_PULSE:      cfg_reg.pulse_ticks <= cfg_data;
                hss_pkg::CFG_DELAY_UNIT: cfg_reg.delay_unit  <= cfg_data[7:0];
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    hss_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (item_en),
        .command    (s_tuser[0]),
        .step_count (s_tdata),
        .cfg        (cfg_reg),
        .result     (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, result_reg};

endmodule

[hw/rtl/hss_checker.sv]
// Port-level checker of the half-step stepper sequencer and its bind statement.
module hss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A rejected move only happens while a move is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> m_tdata[16])
        else $error("rejection reported while idle");

    // Coils are only driven during a move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] != 4'd0) |-> m_tdata[16])
        else $error("coils driven while idle");

    // Driven coils always match the reported phase pattern's coil count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] != 4'd0)
            |-> ($countones(m_tdata[3:0]) == (m_tdata[4] ? 2 : 1)))
        else $error("coil pattern does not fit the phase");

    // No result is shown right after reset.
    assert property (@(posedge aclk) !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind half_step_stepper_sequencer hss_checker u_hss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/testbench.sv]
// Self-checking testbench for the half-step stepper sequencer with a predicting scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Motion stages of the step engine as the predictor tracks them.
    typedef enum logic [1:0] {
        MS_IDLE  = 2'd0,
        MS_ON    = 2'd1,
        MS_OFF   = 2'd2,
        MS_PAUSE = 2'd3
    } motion_stage_t;

    // Idle patterns of the two channels.
    typedef enum int {
        FLOW_FREE    = 0,
        FLOW_SRC_GAP = 1,
        FLOW_SNK_GAP = 2,
        FLOW_BOTH    = 3
    } flow_mode_t;

    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned RANDOM_ITEMS   = 1550;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [15:0] COUNT_MOST_NEG = 16'h8000;
    localparam logic [15:0] COUNT_MOST_POS = 16'h7FFF;

    // Predicts the coil drive for each accepted item and checks the results in order.
    class half_step_scoreboard_t;
        bit [6:0]             speed;
        bit [15:0]            pulse_ticks;
        bit [7:0]             delay_unit;
        bit [2:0]             phase;
        int unsigned          position;
        int unsigned          steps_left;
        bit                   backwards;
        motion_stage_t        stage;
        int unsigned          tick_count;
        hss_pkg::hss_result_t expected_drive[$];
        int unsigned          failures;

        function new();
            speed       = hss_pkg::SPEED_RESET;
            pulse_ticks = hss_pkg::PULSE_RESET;
            delay_unit  = hss_pkg::DELAY_UNIT_RESET;
            phase       = 3'd0;
            position    = 0;
            steps_left  = 0;
            backwards   = 1'b0;
            stage       = MS_IDLE;
            tick_count  = 0;
            failures    = 0;
        endfunction

        function void set_reg(logic [hss_pkg::CFG_IDX_W-1:0] idx,
                              logic [hss_pkg::CFG_DATA_W-1:0] value);
            if (idx == hss_pkg::CFG_SPEED) begin
                speed = value[6:0];
            end else if (idx == hss_pkg::CFG_PULSE) begin
                pulse_ticks = value;
            end else if (idx == hss_pkg::CFG_DELAY_UNIT) begin
                delay_unit = value[7:0];
            end
        endfunction

        function int unsigned pulse_len();
            return (pulse_ticks == 16'd0) ? 1 : int'(pulse_ticks);
        endfunction

        function int unsigned pause_len();
            return (speed >= hss_pkg::SPEED_FULL) ? 0
                                                  : (100 - int'(speed)) * int'(delay_unit);
        endfunction

        function void begin_half_step();
            phase      = backwards ? phase - 3'd1 : phase + 3'd1;
            stage      = MS_ON;
            tick_count = 0;
        endfunction

        function void close_pause();
            if (steps_left != 0) begin
                begin_half_step();
            end else begin
                stage      = MS_IDLE;
                tick_count = 0;
            end
        endfunction

        // One time tick through the on, off and pause stages.
        function void advance_tick();
            case (stage)
                MS_ON: begin
                    tick_count++;
                    if (tick_count >= pulse_len()) begin
                        stage      = MS_OFF;
                        tick_count = 0;
                    end
                end
                MS_OFF: begin
                    tick_count++;
                    if (tick_count >= pulse_len()) begin
                        if (backwards) begin
                            position = (position == 0) ? hss_pkg::POSITIONS - 1
                                                       : position - 1;
                        end else begin
                            position = (position + 1 >= hss_pkg::POSITIONS) ? 0
                                                                            : position + 1;
                        end
                        if (steps_left != 0) begin
                            steps_left--;
                        end
                        stage      = MS_PAUSE;
                        tick_count = 0;
                        if (pause_len() == 0) begin
                            close_pause();
                        end
                    end
                end
                MS_PAUSE: begin
                    tick_count++;
                    if (tick_count >= pause_len()) begin
                        close_pause();
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function bit is_busy();
            return stage != MS_IDLE;
        endfunction

        function int unsigned pending();
            return expected_drive.size();
        endfunction

        // Applies one accepted item and queues the result it must produce.
        function void note_item(logic cmd, logic [15:0] count);
            hss_pkg::hss_result_t res;
            logic                 rejected;
            rejected = 1'b0;
            if (cmd == hss_pkg::CMD_MOVE) begin
                if (stage != MS_IDLE) begin
                    rejected = 1'b1;
                end else if (count != 16'd0) begin
                    backwards  = count[15];
                    steps_left = backwards ? 32'h10000 - int'(count) : int'(count);
                    begin_half_step();
                end
            end else begin
                advance_tick();
            end
            res.coils    = (stage == MS_ON) ? coil_of(phase) : 4'd0;
            res.phase    = phase;
            res.position = position[hss_pkg::OUT_POS_W-1:0];
            res.busy_res = (stage != MS_IDLE);
            res.rejected = rejected;
            expected_drive = {expected_drive, res};
        endfunction

        function logic [3:0] coil_of(bit [2:0] ph);
            logic [3:0] pattern [8];
            pattern = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
            return pattern[ph];
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t ns: %s", $time, msg);
            end
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(logic [23:0] word);
            hss_pkg::hss_result_t got;
            hss_pkg::hss_result_t want;
            got = word[17:0];
            if (expected_drive.size() == 0) begin
                note_failure($sformatf("unexpected result %h", word));
                return;
            end
            want = expected_drive.pop_front();
            if (got.coils !== want.coils || got.phase !== want.phase ||
                got.position !== want.position || got.busy_res !== want.busy_res ||
                got.rejected !== want.rejected || word[23:18] !== 6'd0) begin
                note_failure($sformatf(
                    {"result mismatch: coils %h/%h phase %0d/%0d position %0d/%0d ",
                     "busy %b/%b rejected %b/%b pad %h (expected/actual)"},
                    want.coils, got.coils, want.phase, got.phase,
                    want.position, got.position, want.busy_res, got.busy_res,
                    want.rejected, got.rejected, word[23:18]));
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = 16'd0;
    logic [0:0]                     s_tuser   = hss_pkg::CMD_TICK;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [23:0]                    m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [hss_pkg::CFG_IDX_W-1:0]  cfg_addr  = hss_pkg::CFG_SPEED;
    logic [hss_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    half_step_scoreboard_t motor = new();
    flow_mode_t            flow  = FLOW_FREE;
    int unsigned           hold_requests = 0;
    int unsigned           hold_seen     = 0;
    int unsigned           hold_left     = 0;

    half_step_stepper_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (flow == FLOW_SNK_GAP) begin
            m_tready <= ($urandom_range(99) >= 75);
        end else if (flow == FLOW_BOTH) begin
            m_tready <= ($urandom_range(99) >= 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            motor.check_result(m_tdata);
        end
    end

    // Offers one item after a random gap and waits for it to be taken.
    task automatic send_item(input logic cmd, input logic [15:0] count);
        int unsigned gap;
        gap = 0;
        if (flow == FLOW_SRC_GAP) begin
            while ($urandom_range(99) < 75) gap++;
        end else if (flow == FLOW_BOTH) begin
            while ($urandom_range(99) < 9) gap++;
        end
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= count;
        do @(posedge aclk); while (!s_tready);
        motor.note_item(cmd, count);
    endtask

    task automatic tick_items(input int unsigned n);
        repeat (n) send_item(hss_pkg::CMD_TICK, 16'd0);
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (motor.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [hss_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value[hss_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        motor.set_reg(idx, value[hss_pkg::CFG_DATA_W-1:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short pulses and pauses, now and then a very long pulse or pause.
    task automatic random_settings();
        int unsigned pick;
        int unsigned spd;
        pick = $urandom_range(99);
        if (pick < 6) begin
            write_reg(hss_pkg::CFG_SPEED, $urandom_range(95, 127));
            write_reg(hss_pkg::CFG_PULSE, 65535);
            write_reg(hss_pkg::CFG_DELAY_UNIT, $urandom_range(0, 255));
        end else if (pick < 12) begin
            write_reg(hss_pkg::CFG_SPEED, 0);
            write_reg(hss_pkg::CFG_PULSE, $urandom_range(1, 3));
            write_reg(hss_pkg::CFG_DELAY_UNIT, 255);
        end else begin
            spd = ($urandom_range(99) < 70) ? $urandom_range(90, 127) : $urandom_range(0, 127);
            write_reg(hss_pkg::CFG_SPEED, spd);
            write_reg(hss_pkg::CFG_PULSE, $urandom_range(0, 6));
            if (spd >= 100) begin
                write_reg(hss_pkg::CFG_DELAY_UNIT, $urandom_range(0, 255));
            end else if (spd < 90) begin
                write_reg(hss_pkg::CFG_DELAY_UNIT, $urandom_range(0, 1));
            end else begin
                write_reg(hss_pkg::CFG_DELAY_UNIT, $urandom_range(0, 6));
            end
        end
    endtask

    // Moves with short counts and ticks when the motor rests, ticks and stray moves while it runs.
    task automatic random_item();
        int unsigned pick;
        logic [15:0] count;
        pick = $urandom_range(99);
        if (!motor.is_busy()) begin
            if (pick < 30) begin
                send_item(hss_pkg::CMD_TICK, 16'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    count = 16'($urandom_range(1, 4));
                end else if (pick < 80) begin
                    count = -16'($urandom_range(1, 4));
                end else if (pick < 90) begin
                    count = 16'd0;
                end else begin
                    count = 16'($urandom_range(5, 12));
                    if ($urandom_range(1) == 1) count = -count;
                end
                send_item(hss_pkg::CMD_MOVE, count);
            end
        end else if (pick < 90) begin
            send_item(hss_pkg::CMD_TICK, 16'($urandom));
        end else begin
            send_item(hss_pkg::CMD_MOVE, 16'($urandom));
        end
    endtask

    // Stimulus and final verdict.
    initial begin
        int unsigned sent;
        int unsigned phase_no;
        int unsigned n;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero pulse length and speed above full: every half-step takes two ticks.
        write_reg(hss_pkg::CFG_PULSE, 0);
        write_reg(hss_pkg::CFG_SPEED, 127);
        write_reg(hss_pkg::CFG_DELAY_UNIT, 255);
        send_item(hss_pkg::CMD_TICK, 16'd0);
        send_item(hss_pkg::CMD_MOVE, 16'd0);
        send_item(hss_pkg::CMD_MOVE, 16'd2);
        send_item(hss_pkg::CMD_MOVE, 16'd5);
        tick_items(4);
        send_item(hss_pkg::CMD_MOVE, 16'hFFFF);
        send_item(hss_pkg::CMD_MOVE, 16'd0);
        tick_items(2);
        drain();

        // Zero speed with zero delay unit, then a one-tick pause.
        write_reg(hss_pkg::CFG_SPEED, 0);
        write_reg(hss_pkg::CFG_DELAY_UNIT, 0);
        write_reg(hss_pkg::CFG_PULSE, 1);
        send_item(hss_pkg::CMD_MOVE, 16'hFFFE);
        tick_items(4);
        drain();
        write_reg(hss_pkg::CFG_SPEED, 99);
        write_reg(hss_pkg::CFG_DELAY_UNIT, 1);
        send_item(hss_pkg::CMD_MOVE, 16'd1);
        tick_items(3);
        drain();

        // Random phases, each with its own settings and flow pattern.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            flow = flow_mode_t'(phase_no % 4);
            random_settings();
            if (phase_no == 2) hold_requests++;
            n = $urandom_range(40, 160);
            repeat (n) random_item();
            sent += n;
            drain();
            phase_no++;
        end

        // Extreme counts: run out any move left over, then the longest backward move and a rejected forward one.
        flow = FLOW_FREE;
        write_reg(hss_pkg::CFG_PULSE, 1);
        write_reg(hss_pkg::CFG_SPEED, 127);
        write_reg(hss_pkg::CFG_DELAY_UNIT, 0);
        while (motor.is_busy()) send_item(hss_pkg::CMD_TICK, 16'd0);
        send_item(hss_pkg::CMD_MOVE, COUNT_MOST_NEG);
        tick_items(6);
        send_item(hss_pkg::CMD_MOVE, COUNT_MOST_POS);
        tick_items(4);
        drain();
        repeat (4) @(posedge aclk);

        if (motor.failures == 0 && motor.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hss_pkg.sv
hw/rtl/hss_engine.sv
hw/rtl/half_step_stepper_sequencer.sv
hw/rtl/hss_checker.sv
sim/testbench.sv
